// File: rtl/core/adc_window_stats_readout_assert.svh
// Assertion macros shared by the block's RTL. Clock and reset are taken from
// the scope of the module that expands them.
`ifndef ADC_WINDOW_STATS_READOUT_ASSERT_SVH
`define ADC_WINDOW_STATS_READOUT_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define AWSR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define AWSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/awsr_pkg.sv
package awsr_pkg;

  localparam int unsigned WindowSamples = 20;
  localparam int unsigned SampleW       = 12;
  localparam int unsigned MaxCount      = 4095;
  localparam int unsigned FullScaleMv   = 3300;
  localparam int unsigned BarMax        = 31;
  localparam int unsigned BarSpanMv     = 3000;
  localparam int unsigned BarW          = 5;
  localparam int unsigned BcdW          = 16;

  localparam int unsigned SumW = $clog2(WindowSamples * MaxCount + 1);
  localparam int unsigned CntW = $clog2(WindowSamples + 1);

  // Division by a constant is a multiplication by a rounded-up reciprocal.
  // With shift = operand bits + ceil(log2(divisor)) the quotient is exact
  // over the whole operand range.
  localparam int unsigned     AvgShift = SumW + $clog2(WindowSamples);
  localparam longint unsigned AvgMultL =
    ((64'd1 << AvgShift) + WindowSamples - 1) / WindowSamples;
  localparam int unsigned     AvgMultW = $clog2(AvgMultL + 1);
  localparam logic [AvgMultW-1:0] AvgMult = AvgMultW'(AvgMultL);

  // Millivolts: count * 3300 / 4095.
  localparam int unsigned     MvShift = SampleW + $clog2(MaxCount);
  localparam longint unsigned MvMultL =
    ((longint'(FullScaleMv) << MvShift) + MaxCount - 1) / MaxCount;
  localparam int unsigned     MvMultW = $clog2(MvMultL + 1);
  localparam logic [MvMultW-1:0] MvMult = MvMultW'(MvMultL);

  // Bar: count * 31 * 3300 / (3000 * 4095).
  localparam longint unsigned BarNum  = longint'(BarMax) * FullScaleMv;
  localparam longint unsigned BarDen  = longint'(BarSpanMv) * MaxCount;
  localparam int unsigned     BarShift = SampleW + $clog2(BarDen);
  localparam longint unsigned BarMultL = ((BarNum << BarShift) + BarDen - 1) / BarDen;
  localparam int unsigned     BarMultW = $clog2(BarMultL + 1);
  localparam logic [BarMultW-1:0] BarMult = BarMultW'(BarMultL);

  // Reciprocals for the decimal digit split of a 12-bit value.
  localparam int unsigned Div10Shift   = SampleW + $clog2(10);
  localparam int unsigned Div10Mult    = ((1 << Div10Shift) + 9) / 10;
  localparam int unsigned Div100Shift  = SampleW + $clog2(100);
  localparam int unsigned Div100Mult   = ((1 << Div100Shift) + 99) / 100;
  localparam int unsigned Div1000Shift = SampleW + $clog2(1000);
  localparam int unsigned Div1000Mult  = ((1 << Div1000Shift) + 999) / 1000;

  typedef enum logic [1:0] {
    RowMin = 2'd0,
    RowMax = 2'd1,
    RowAvg = 2'd2
  } row_kind_e;

  typedef enum logic [1:0] {
    SeqIdle,
    SeqMin,
    SeqMax,
    SeqAvg
  } seq_state_e;

  typedef struct packed {
    logic [SampleW-1:0] min_val;
    logic [SampleW-1:0] max_val;
    logic [SumW-1:0]    sum;
  } win_t;

  typedef struct packed {
    row_kind_e          kind;
    logic [SampleW-1:0] count;
    logic               last;
  } row_t;

  // Four BCD digits of a 12-bit value (below 4096), thousands in the top nibble.
  function automatic logic [BcdW-1:0] to_bcd4(input logic [SampleW-1:0] v);
    logic [31:0] q10;
    logic [31:0] q100;
    logic [31:0] q1000;
    logic [3:0]  d0;
    logic [3:0]  d1;
    logic [3:0]  d2;
    logic [3:0]  d3;
    q10   = (32'(v) * Div10Mult) >> Div10Shift;
    q100  = (32'(v) * Div100Mult) >> Div100Shift;
    q1000 = (32'(v) * Div1000Mult) >> Div1000Shift;
    d3 = q1000[3:0];
    d2 = 4'(q100 - q1000 * 32'd10);
    d1 = 4'(q10 - q100 * 32'd10);
    d0 = 4'(32'(v) - q10 * 32'd10);
    return {d3, d2, d1, d0};
  endfunction

endpackage

// File: rtl/core/awsr_accum.sv
module awsr_accum import awsr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [SampleW-1:0] sample_i,
  output logic               in_stall_o,
  input  logic               snap_take_i,
  output logic               snap_valid_o,
  output win_t               snap_o
);

  logic [SampleW-1:0] min_q, min_d;
  logic [SampleW-1:0] max_q, max_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               snap_valid_q, snap_valid_d;
  win_t               snap_q, snap_d;

  logic               win_end;
  logic               first;
  logic               accept;
  logic [SampleW-1:0] new_min;
  logic [SampleW-1:0] new_max;
  logic [SumW-1:0]    new_sum;

  assign win_end = (cnt_q == CntW'(WindowSamples - 1));
  assign first   = (cnt_q == '0);

  // Only the closing sample of a window waits, and only while the previous
  // window's totals have not yet been picked up.
  assign in_stall_o = win_end && snap_valid_q && !snap_take_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign new_min = (first || (sample_i < min_q)) ? sample_i : min_q;
  assign new_max = (first || (sample_i > max_q)) ? sample_i : max_q;
  assign new_sum = sum_q + SumW'(sample_i);

  always_comb begin
    min_d        = min_q;
    max_d        = max_q;
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    snap_d       = snap_q;
    snap_valid_d = snap_valid_q && !snap_take_i;
    if (accept) begin
      if (win_end) begin
        min_d          = '0;
        max_d          = '0;
        sum_d          = '0;
        cnt_d          = '0;
        snap_d.min_val = new_min;
        snap_d.max_val = new_max;
        snap_d.sum     = new_sum;
        snap_valid_d   = 1'b1;
      end else begin
        min_d = new_min;
        max_d = new_max;
        sum_d = new_sum;
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q        <= '0;
      max_q        <= '0;
      sum_q        <= '0;
      cnt_q        <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      min_q        <= min_d;
      max_q        <= max_d;
      sum_q        <= sum_d;
      cnt_q        <= cnt_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

// File: rtl/core/awsr_rowseq.sv
module awsr_rowseq import awsr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic snap_valid_i,
  input  win_t snap_i,
  output logic snap_take_o,
  output logic row_valid_o,
  output row_t row_o,
  input  logic row_stall_i
);

  seq_state_e state_q, state_d;

  logic [SampleW-1:0] min_q;
  logic [SampleW-1:0] max_q;
  logic [SampleW-1:0] avg_q;

  logic [SumW+AvgMultW-1:0] avg_prod;
  logic                     row_ready;

  assign row_ready = !row_stall_i;

  // Average of the window: sum times the reciprocal of the window length.
  assign avg_prod = (SumW + AvgMultW)'(snap_i.sum) * (SumW + AvgMultW)'(AvgMult);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SeqIdle: if (snap_valid_i) state_d = SeqMin;
      SeqMin:  if (row_ready) state_d = SeqMax;
      SeqMax:  if (row_ready) state_d = SeqAvg;
      SeqAvg: begin
        if (row_ready) state_d = snap_valid_i ? SeqMin : SeqIdle;
      end
      default: state_d = SeqIdle;
    endcase
  end

  always_comb begin
    snap_take_o = 1'b0;
    row_valid_o = 1'b0;
    row_o.kind  = RowMin;
    row_o.count = min_q;
    row_o.last  = 1'b0;
    unique case (state_q)
      SeqIdle: begin
        snap_take_o = snap_valid_i;
      end
      SeqMin: begin
        row_valid_o = 1'b1;
      end
      SeqMax: begin
        row_valid_o = 1'b1;
        row_o.kind  = RowMax;
        row_o.count = max_q;
      end
      SeqAvg: begin
        row_valid_o = 1'b1;
        row_o.kind  = RowAvg;
        row_o.count = avg_q;
        row_o.last  = 1'b1;
        snap_take_o = snap_valid_i && row_ready;
      end
      default: begin
        snap_take_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeqIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_take_o) begin
      min_q <= snap_i.min_val;
      max_q <= snap_i.max_val;
      avg_q <= SampleW'(avg_prod >> AvgShift);
    end
  end

endmodule

// File: rtl/core/awsr_rowfmt.sv
module awsr_rowfmt import awsr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               row_valid_i,
  input  row_t               row_i,
  output logic               row_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         row_kind_o,
  output logic [SampleW-1:0] count_value_o,
  output logic [SampleW-1:0] millivolts_o,
  output logic [BcdW-1:0]    count_bcd_o,
  output logic [BcdW-1:0]    millivolt_bcd_o,
  output logic [BarW-1:0]    bar_length_o,
  output logic               last_row_o
);

  localparam int unsigned MvProdW  = SampleW + MvMultW;
  localparam int unsigned BarProdW = SampleW + BarMultW;

  // Three stages: row latch, scaling, decimal conversion (the output register).
  logic               s1_valid_q;
  row_t               s1_row_q;
  logic               s2_valid_q;
  row_t               s2_row_q;
  logic [SampleW-1:0] s2_mv_q;
  logic [BarW-1:0]    s2_bar_q;
  logic               s3_valid_q;
  row_t               s3_row_q;
  logic [SampleW-1:0] s3_mv_q;
  logic [BarW-1:0]    s3_bar_q;
  logic [BcdW-1:0]    s3_cnt_bcd_q;
  logic [BcdW-1:0]    s3_mv_bcd_q;

  logic s1_ready;
  logic s2_ready;
  logic s3_ready;

  logic [MvProdW-1:0]  mv_prod;
  logic [BarProdW-1:0] bar_prod;
  logic [BarProdW-1:0] bar_full;
  logic [BarW-1:0]     bar_len;

  assign s3_ready    = !s3_valid_q || !out_stall_i;
  assign s2_ready    = !s2_valid_q || s3_ready;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign row_stall_o = !s1_ready;

  assign mv_prod  = MvProdW'(s1_row_q.count) * MvProdW'(MvMult);
  assign bar_prod = BarProdW'(s1_row_q.count) * BarProdW'(BarMult);
  assign bar_full = bar_prod >> BarShift;
  // Counts above the 3.0 V span saturate the bar.
  assign bar_len  = (bar_full > BarProdW'(BarMax)) ? BarW'(BarMax) : BarW'(bar_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= row_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && row_valid_i) begin
      s1_row_q <= row_i;
    end
    if (s2_ready && s1_valid_q) begin
      s2_row_q <= s1_row_q;
      s2_mv_q  <= SampleW'(mv_prod >> MvShift);
      s2_bar_q <= bar_len;
    end
    if (s3_ready && s2_valid_q) begin
      s3_row_q     <= s2_row_q;
      s3_mv_q      <= s2_mv_q;
      s3_bar_q     <= s2_bar_q;
      s3_cnt_bcd_q <= to_bcd4(s2_row_q.count);
      s3_mv_bcd_q  <= to_bcd4(s2_mv_q);
    end
  end

  assign out_valid_o     = s3_valid_q;
  assign row_kind_o      = s3_row_q.kind;
  assign count_value_o   = s3_row_q.count;
  assign millivolts_o    = s3_mv_q;
  assign count_bcd_o     = s3_cnt_bcd_q;
  assign millivolt_bcd_o = s3_mv_bcd_q;
  assign bar_length_o    = s3_bar_q;
  assign last_row_o      = s3_row_q.last;

endmodule

// File: rtl/core/adc_window_stats_readout.sv
// Channel   Direction  Handshake                Payload
// input     in         in_valid_i/in_stall_o    sample_i
// rows      out        out_valid_o/out_stall_i  row_kind_o, count_value_o, millivolts_o,
//                                               count_bcd_o, millivolt_bcd_o,
//                                               bar_length_o, last_row_o
//
// One sample request is taken per cycle unless in_stall_o is high; the running minimum,
// maximum and sum update in the cycle of acceptance. The closing sample of a window
// starts three rows, which leave one per cycle while the rows do not stall; the first
// row passes the snapshot, sequencer, row latch, scaling and output registers. The
// closing sample of a window is held off only while the previous window's totals still
// wait for the row sequencer. Reset clears all running statistics and empties the row
// pipeline. A stall on the rows holds the output register and backs up to the input.
module adc_window_stats_readout import awsr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [SampleW-1:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         row_kind_o,
  output logic [SampleW-1:0] count_value_o,
  output logic [SampleW-1:0] millivolts_o,
  output logic [BcdW-1:0]    count_bcd_o,
  output logic [BcdW-1:0]    millivolt_bcd_o,
  output logic [BarW-1:0]    bar_length_o,
  output logic               last_row_o
);

  logic snap_valid;
  win_t snap;
  logic snap_take;
  logic row_valid;
  row_t row;
  logic row_stall;

  awsr_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .sample_i     (sample_i),
    .in_stall_o   (in_stall_o),
    .snap_take_i  (snap_take),
    .snap_valid_o (snap_valid),
    .snap_o       (snap)
  );

  awsr_rowseq u_rowseq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .snap_take_o  (snap_take),
    .row_valid_o  (row_valid),
    .row_o        (row),
    .row_stall_i  (row_stall)
  );

  awsr_rowfmt u_rowfmt (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .row_valid_i     (row_valid),
    .row_i           (row),
    .row_stall_o     (row_stall),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .row_kind_o      (row_kind_o),
    .count_value_o   (count_value_o),
    .millivolts_o    (millivolts_o),
    .count_bcd_o     (count_bcd_o),
    .millivolt_bcd_o (millivolt_bcd_o),
    .bar_length_o    (bar_length_o),
    .last_row_o      (last_row_o)
  );

`include "adc_window_stats_readout_assert.svh"

  `AWSR_ASSERT_IMPL(a_last_on_avg, out_valid_o, last_row_o == (row_kind_o == RowAvg), "last_row does not match the average row")
  `AWSR_ASSERT_IMPL(a_mv_not_above_count, out_valid_o, millivolts_o <= count_value_o, "millivolts exceed the count")
  `AWSR_ASSERT_IMPL(a_snap_min_max, snap_valid, snap.min_val <= snap.max_val, "window minimum above maximum")
  `AWSR_ASSERT_NEXT(a_snap_kept, snap_valid && !snap_take, snap_valid, "window totals dropped before being taken")

endmodule
